// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TCW_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define TCW_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Default screen geometry.
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // Fixed field widths.
   localparam int CMD_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int CUR_COL_W = 7;
   localparam int CUR_ROW_W = 5;

   // Signed width that holds a coordinate plus a rectangle extent.
   localparam int CRD_W = 10;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_WRITE_CURSOR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_POS    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_CURSOR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FILL         = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BOX          = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ         = 3'd6;

   // Character and attribute constants.
   localparam logic [BYTE_W-1:0] CHR_NL     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHR_BS     = 8'h08;
   localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_DASH   = 8'h2D;
   localparam logic [BYTE_W-1:0] CHR_BAR    = 8'h7C;
   localparam logic [BYTE_W-1:0] CHR_PLUS   = 8'h2B;
   localparam logic [BYTE_W-1:0] BLANK_ATTR = 8'h07;

   // One screen cell.
   typedef struct packed {
      logic [BYTE_W-1:0] chr;
      logic [BYTE_W-1:0] atr;
   } cell_type;

endpackage

`default_nettype wire

// ===== hdl/tcw_if.sv =====
// ----------------------------------------------------------------------------
// tcw_req_if / tcw_rsp_if
// Valid/ready channels for console commands and their response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
   import tcw_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [BYTE_W-1:0] col;
   logic signed [BYTE_W-1:0] row;
   logic [BYTE_W-1:0]        rect_width;
   logic [BYTE_W-1:0]        rect_height;
   logic [BYTE_W-1:0]        char_code;
   logic [BYTE_W-1:0]        attribute;

   modport source (
      output valid, command, col, row, rect_width, rect_height, char_code, attribute,
      input  ready
   );
   modport sink (
      input  valid, command, col, row, rect_width, rect_height, char_code, attribute,
      output ready
   );
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CUR_COL_W-1:0] cursor_col;
   logic [CUR_ROW_W-1:0] cursor_row;
   logic [BYTE_W-1:0]    cell_char;
   logic [BYTE_W-1:0]    cell_attribute;

   modport source (
      output valid, cursor_col, cursor_row, cell_char, cell_attribute,
      input  ready
   );
   modport sink (
      input  valid, cursor_col, cursor_row, cell_char, cell_attribute,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]   wr_addr,
   input  tcw_pkg::cell_type                          wr_data,
   input  logic                                       rd_en,
   input  logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]   rd_addr,
   output tcw_pkg::cell_type                          rd_data
);
   import tcw_pkg::*;

   // A row occupies a power-of-two slot so the address is {row, column}.
   localparam int DEPTH = ROWS * (2 ** $clog2(COLUMNS));

   cell_type mem [0:DEPTH-1];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with cursor, scroll, fill, box and cell read.
//
// Commands arrive as words on req_chan; every command returns exactly one
// word on rsp_chan carrying the cursor after the command and, for a cell
// read, the cell's character and attribute (zero otherwise).
// One command is worked at a time; req_chan.ready is high only while idle.
// Work per command: plain write, write at position, control character
// and set cursor need no walk; a cell read is a registered memory read;
// clear writes every cell and fill every clipped cell; box draws its
// horizontal edges, then its vertical edges, then its four corners,
// skipping an edge pair of zero extent; a write that scrolls copies the
// rows up, drains the copy and blanks the last row. The block is idle
// again on the edge that raises valid, so a new command is accepted
// only once the last one has raised its response. Long commands are
// set by the memory's single write port: one cell per cycle. A finished
// response waits in an output register while the next command is
// accepted; the block then holds until that register frees.
// Reset clears the cursor to (0, 0) and drops any pending response; the
// cell store is not cleared, so software clears the screen before reading.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_chan,
   tcw_rsp_if.source rsp_chan
);
   import tcw_pkg::*;

`include "assert_macros.svh"

   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);
   localparam int AW = CW + RW;

   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic signed [CRD_W-1:0] COLS_S = CRD_W'(COLUMNS);
   localparam logic signed [CRD_W-1:0] ROWS_S = CRD_W'(ROWS);
   localparam logic signed [CRD_W-1:0] ONE_S  = CRD_W'(1);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_PUT    = 12'b0000_0000_0010,
      S_READ   = 12'b0000_0000_0100,
      S_READW  = 12'b0000_0000_1000,
      S_FILL   = 12'b0000_0001_0000,
      S_BOXH   = 12'b0000_0010_0000,
      S_BOXV   = 12'b0000_0100_0000,
      S_BOXC   = 12'b0000_1000_0000,
      S_SCROLL = 12'b0001_0000_0000,
      S_SDRAIN = 12'b0010_0000_0000,
      S_BLANK  = 12'b0100_0000_0000,
      S_DONE   = 12'b1000_0000_0000
   } state_type;

   // Control registers.
   state_type     state_ff, state_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          pend_ff, pend_in;

   // Command and walker registers.
   logic                     put_pos_ff, put_pos_in;
   logic [BYTE_W-1:0]        char_ff, char_in;
   logic [BYTE_W-1:0]        attr_ff, attr_in;
   logic signed [CRD_W-1:0]  box_x_ff, box_x_in;
   logic signed [CRD_W-1:0]  box_y_ff, box_y_in;
   logic signed [CRD_W-1:0]  box_xe_ff, box_xe_in;
   logic signed [CRD_W-1:0]  box_ye_ff, box_ye_in;
   logic [BYTE_W-1:0]        rect_w_ff, rect_w_in;
   logic [BYTE_W-1:0]        rect_h_ff, rect_h_in;
   logic [BYTE_W-1:0]        box_i_ff, box_i_in;
   logic                     box_side_ff, box_side_in;
   logic                     read_hit_ff, read_hit_in;
   logic [CW-1:0]            walk_col_ff, walk_col_in;
   logic [RW-1:0]            walk_row_ff, walk_row_in;
   logic [CW-1:0]            col_first_ff, col_first_in;
   logic [CW-1:0]            col_last_ff, col_last_in;
   logic [RW-1:0]            row_last_ff, row_last_in;
   logic [AW-1:0]            pend_addr_ff, pend_addr_in;
   cell_type                 cell_data_ff, cell_data_in;

   // Response payload registers.
   logic [CUR_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [CUR_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [BYTE_W-1:0]    rsp_chr_ff, rsp_chr_in;
   logic [BYTE_W-1:0]    rsp_atr_ff, rsp_atr_in;

   // Memory ports.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   cell_type      wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   cell_type      rd_data;

   // Request decode.
   logic                    accept;
   logic                    out_free;
   logic signed [CRD_W-1:0] req_x, req_y, req_w, req_h;
   logic signed [CRD_W-1:0] x_end, y_end, x_lo, y_lo, x_hi, y_hi, x_hi_m1, y_hi_m1;
   logic                    x_ok, y_ok, fill_empty;

   // Shared coordinate unit.
   logic signed [CRD_W-1:0] box_sum, tx, ty;
   logic                    tgt_ok;
   logic [AW-1:0]           tgt_addr;

   // Walker step.
   logic          walk_row_end, walk_end;
   logic [CW-1:0] walk_col_nx;
   logic [RW-1:0] walk_row_nx;

   // Checked conditions.
   logic cursor_ok, copy_phase, scroll_phase;

   tcw_cell_ram #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Signed coordinates and clipped rectangle bounds of the incoming word.
   assign req_x = {{(CRD_W-BYTE_W){req_chan.col[BYTE_W-1]}}, req_chan.col};
   assign req_y = {{(CRD_W-BYTE_W){req_chan.row[BYTE_W-1]}}, req_chan.row};
   assign req_w = {{(CRD_W-BYTE_W){1'b0}}, req_chan.rect_width};
   assign req_h = {{(CRD_W-BYTE_W){1'b0}}, req_chan.rect_height};

   assign x_end   = req_x + req_w;
   assign y_end   = req_y + req_h;
   assign x_lo    = (req_x < 0) ? '0 : req_x;
   assign y_lo    = (req_y < 0) ? '0 : req_y;
   assign x_hi    = (x_end > COLS_S) ? COLS_S : x_end;
   assign y_hi    = (y_end > ROWS_S) ? ROWS_S : y_end;
   assign x_hi_m1 = x_hi - ONE_S;
   assign y_hi_m1 = y_hi - ONE_S;
   assign fill_empty = (x_hi <= x_lo) || (y_hi <= y_lo);
   assign x_ok = (req_x >= 0) && (req_x < COLS_S);
   assign y_ok = (req_y >= 0) && (req_y < ROWS_S);

   // Box edge and corner coordinates; one adder serves both edge walks.
   always_comb begin
      box_sum = ((state_ff == S_BOXH) ? box_x_ff : box_y_ff)
              + {{(CRD_W-BYTE_W){1'b0}}, box_i_ff};
      tx = box_x_ff;
      ty = box_y_ff;
      case (state_ff)
         S_BOXH: begin
            tx = box_sum;
            ty = box_side_ff ? box_ye_ff : box_y_ff;
         end
         S_BOXV: begin
            tx = box_side_ff ? box_xe_ff : box_x_ff;
            ty = box_sum;
         end
         S_BOXC: begin
            tx = box_i_ff[0] ? box_xe_ff : box_x_ff;
            ty = box_i_ff[1] ? box_ye_ff : box_y_ff;
         end
         default: begin
         end
      endcase
   end

   assign tgt_ok   = (tx >= 0) && (tx < COLS_S) && (ty >= 0) && (ty < ROWS_S);
   assign tgt_addr = {ty[RW-1:0], tx[CW-1:0]};

   assign walk_row_end = (walk_col_ff == col_last_ff);
   assign walk_end     = walk_row_end && (walk_row_ff == row_last_ff);
   assign walk_col_nx  = walk_row_end ? col_first_ff : walk_col_ff + 1'b1;
   assign walk_row_nx  = walk_row_end ? walk_row_ff + 1'b1 : walk_row_ff;

   // Source row of a scroll copy: the row below the destination.
   function automatic logic [RW-1:0] walk_row_nx_src(input logic [RW-1:0] r);
      walk_row_nx_src = r + 1'b1;
   endfunction

   always_comb begin
      logic     finish;
      logic     line_adv;
      logic     put_en;
      logic [AW-1:0] put_addr;
      cell_type put_data;

      finish   = 1'b0;
      line_adv = 1'b0;
      put_en   = 1'b0;
      put_addr = tgt_addr;
      put_data = cell_type'{chr: char_ff, atr: attr_ff};

      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      pend_in      = (state_ff == S_SCROLL);
      pend_addr_in = {walk_row_ff, walk_col_ff};
      put_pos_in   = put_pos_ff;
      char_in      = char_ff;
      attr_in      = attr_ff;
      box_x_in     = box_x_ff;
      box_y_in     = box_y_ff;
      box_xe_in    = box_xe_ff;
      box_ye_in    = box_ye_ff;
      rect_w_in    = rect_w_ff;
      rect_h_in    = rect_h_ff;
      box_i_in     = box_i_ff;
      box_side_in  = box_side_ff;
      read_hit_in  = read_hit_ff;
      walk_col_in  = walk_col_ff;
      walk_row_in  = walk_row_ff;
      col_first_in = col_first_ff;
      col_last_in  = col_last_ff;
      row_last_in  = row_last_ff;
      cell_data_in = cell_data_ff;
      rd_en        = 1'b0;
      rd_addr      = {box_y_ff[RW-1:0], box_x_ff[CW-1:0]};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               put_pos_in   = (req_chan.command == CMD_WRITE_POS);
               char_in      = req_chan.char_code;
               attr_in      = req_chan.attribute;
               box_x_in     = req_x;
               box_y_in     = req_y;
               box_xe_in    = x_end - ONE_S;
               box_ye_in    = y_end - ONE_S;
               rect_w_in    = req_chan.rect_width;
               rect_h_in    = req_chan.rect_height;
               box_i_in     = '0;
               box_side_in  = 1'b0;
               read_hit_in  = x_ok && y_ok;
               cell_data_in = '0;
               walk_col_in  = x_lo[CW-1:0];
               walk_row_in  = y_lo[RW-1:0];
               col_first_in = x_lo[CW-1:0];
               col_last_in  = x_hi_m1[CW-1:0];
               row_last_in  = y_hi_m1[RW-1:0];
               case (req_chan.command)
                  CMD_WRITE_CURSOR, CMD_WRITE_POS: begin
                     state_in = S_PUT;
                  end
                  CMD_CLEAR: begin
                     char_in      = CHR_SPACE;
                     walk_col_in  = '0;
                     walk_row_in  = '0;
                     col_first_in = '0;
                     col_last_in  = LAST_COL;
                     row_last_in  = LAST_ROW;
                     cur_col_in   = '0;
                     cur_row_in   = '0;
                     state_in     = S_FILL;
                  end
                  CMD_SET_CURSOR: begin
                     if (x_ok) begin
                        cur_col_in = req_chan.col[CW-1:0];
                     end
                     if (y_ok) begin
                        cur_row_in = req_chan.row[RW-1:0];
                     end
                     state_in = S_DONE;
                  end
                  CMD_FILL: begin
                     state_in = fill_empty ? S_DONE : S_FILL;
                  end
                  CMD_BOX: begin
                     state_in = S_BOXH;
                  end
                  CMD_READ: begin
                     state_in = (x_ok && y_ok) ? S_READ : S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_PUT: begin
            if (put_pos_ff) begin
               put_en = tgt_ok;
               finish = 1'b1;
            end else begin
               if (char_ff == CHR_NL) begin
                  cur_col_in = '0;
                  line_adv   = 1'b1;
               end else if (char_ff == CHR_CR) begin
                  cur_col_in = '0;
               end else if (char_ff == CHR_BS) begin
                  if (cur_col_ff != '0) begin
                     cur_col_in = cur_col_ff - 1'b1;
                  end
               end else begin
                  put_en   = 1'b1;
                  put_addr = {cur_row_ff, cur_col_ff};
                  if (cur_col_ff == LAST_COL) begin
                     cur_col_in = '0;
                     line_adv   = 1'b1;
                  end else begin
                     cur_col_in = cur_col_ff + 1'b1;
                  end
               end
               if (line_adv && (cur_row_ff == LAST_ROW)) begin
                  // Copy rows 1..last up by one, then blank the last row.
                  walk_col_in  = '0;
                  walk_row_in  = '0;
                  col_first_in = '0;
                  col_last_in  = LAST_COL;
                  row_last_in  = LAST_ROW - 1'b1;
                  state_in     = S_SCROLL;
               end else begin
                  if (line_adv) begin
                     cur_row_in = cur_row_ff + 1'b1;
                  end
                  finish = 1'b1;
               end
            end
         end

         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_READW;
         end

         S_READW: begin
            cell_data_in = read_hit_ff ? rd_data : '0;
            state_in     = S_DONE;
         end

         S_FILL: begin
            put_en      = 1'b1;
            put_addr    = {walk_row_ff, walk_col_ff};
            walk_col_in = walk_col_nx;
            walk_row_in = walk_row_nx;
            if (walk_end) begin
               state_in = S_DONE;
            end
         end

         S_BOXH: begin
            put_data = cell_type'{chr: CHR_DASH, atr: attr_ff};
            if (rect_w_ff == '0) begin
               box_i_in    = '0;
               box_side_in = 1'b0;
               state_in    = S_BOXV;
            end else begin
               put_en      = tgt_ok;
               box_side_in = !box_side_ff;
               if (box_side_ff) begin
                  if (box_i_ff == rect_w_ff - 1'b1) begin
                     box_i_in = '0;
                     state_in = S_BOXV;
                  end else begin
                     box_i_in = box_i_ff + 1'b1;
                  end
               end
            end
         end

         S_BOXV: begin
            put_data = cell_type'{chr: CHR_BAR, atr: attr_ff};
            if (rect_h_ff == '0) begin
               box_i_in    = '0;
               box_side_in = 1'b0;
               state_in    = S_BOXC;
            end else begin
               put_en      = tgt_ok;
               box_side_in = !box_side_ff;
               if (box_side_ff) begin
                  if (box_i_ff == rect_h_ff - 1'b1) begin
                     box_i_in = '0;
                     state_in = S_BOXC;
                  end else begin
                     box_i_in = box_i_ff + 1'b1;
                  end
               end
            end
         end

         S_BOXC: begin
            put_data = cell_type'{chr: CHR_PLUS, atr: attr_ff};
            put_en   = tgt_ok;
            box_i_in = box_i_ff + 1'b1;
            if (box_i_ff[1:0] == 2'b11) begin
               state_in = S_DONE;
            end
         end

         S_SCROLL: begin
            // Read the cell one row below; it is written back next cycle.
            rd_en       = 1'b1;
            rd_addr     = {walk_row_nx_src(walk_row_ff), walk_col_ff};
            walk_col_in = walk_col_nx;
            walk_row_in = walk_row_nx;
            if (walk_end) begin
               state_in = S_SDRAIN;
            end
         end

         S_SDRAIN: begin
            walk_col_in = '0;
            walk_row_in = LAST_ROW;
            row_last_in = LAST_ROW;
            state_in    = S_BLANK;
         end

         S_BLANK: begin
            put_en      = 1'b1;
            put_addr    = {walk_row_ff, walk_col_ff};
            put_data    = cell_type'{chr: CHR_SPACE, atr: BLANK_ATTR};
            walk_col_in = walk_col_nx;
            if (walk_end) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            finish = 1'b1;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hand the response word to the output register when it is free.
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_chr_in   = rsp_chr_ff;
      rsp_atr_in   = rsp_atr_ff;
      if (finish) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = CUR_COL_W'(cur_col_in);
            rsp_row_in   = CUR_ROW_W'(cur_row_in);
            rsp_chr_in   = cell_data_ff.chr;
            rsp_atr_in   = cell_data_ff.atr;
            state_in     = S_IDLE;
         end else begin
            state_in = S_DONE;
         end
      end

      // The delayed scroll copy owns the write port whenever it is pending.
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = rd_data;
      end else begin
         wr_en   = put_en;
         wr_addr = put_addr;
         wr_data = put_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      put_pos_ff   <= put_pos_in;
      char_ff      <= char_in;
      attr_ff      <= attr_in;
      box_x_ff     <= box_x_in;
      box_y_ff     <= box_y_in;
      box_xe_ff    <= box_xe_in;
      box_ye_ff    <= box_ye_in;
      rect_w_ff    <= rect_w_in;
      rect_h_ff    <= rect_h_in;
      box_i_ff     <= box_i_in;
      box_side_ff  <= box_side_in;
      read_hit_ff  <= read_hit_in;
      walk_col_ff  <= walk_col_in;
      walk_row_ff  <= walk_row_in;
      col_first_ff <= col_first_in;
      col_last_ff  <= col_last_in;
      row_last_ff  <= row_last_in;
      cell_data_ff <= cell_data_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_chr_ff   <= rsp_chr_in;
      rsp_atr_ff   <= rsp_atr_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.cursor_col     = rsp_col_ff;
   assign rsp_chan.cursor_row     = rsp_row_ff;
   assign rsp_chan.cell_char      = rsp_chr_ff;
   assign rsp_chan.cell_attribute = rsp_atr_ff;

   assign cursor_ok    = (cur_col_ff <= LAST_COL) && (cur_row_ff <= LAST_ROW);
   assign copy_phase   = (state_ff == S_SCROLL) || (state_ff == S_SDRAIN);
   assign scroll_phase = (state_ff == S_SCROLL) || (state_ff == S_BLANK);

   `TCW_ASSERT(a_cursor_in_grid, clock, reset, cursor_ok, "cursor left the grid")
   `TCW_ASSERT_IMPL(a_pend_in_scroll, clock, reset, pend_ff, copy_phase, "copy outside a scroll")
   `TCW_ASSERT_IMPL(a_scroll_last_row, clock, reset, scroll_phase, cur_row_ff == LAST_ROW, "bad scroll")

endmodule

`default_nettype wire
